// ----- src/hotp_pkg.sv -----
// ----------------------------------------------------------------------------
// hotp_pkg
// shared types, constants and a helper function of the one-time password block
// ----------------------------------------------------------------------------
package hotp_pkg;

    localparam int KEY_BYTES_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_LEN   = 2'd0;
    localparam logic [1:0] REG_DIGITS    = 2'd1;
    localparam logic [1:0] REG_TIME_STEP = 2'd2;

    // request modes
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_HOTP = 2'd1;
    localparam logic [1:0] MODE_TOTP = 2'd2;

    // sha-1 core operations
    localparam logic [1:0] CORE_NOP  = 2'd0;
    localparam logic [1:0] CORE_INIT = 2'd1;
    localparam logic [1:0] CORE_STEP = 2'd2;
    localparam logic [1:0] CORE_FOLD = 2'd3;

    localparam logic [6:0] ROUNDS = 7'd80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [7:0]  IPAD = 8'h36;
    localparam logic [7:0]  OPAD = 8'h5C;
    localparam logic [31:0] PAD_WORD       = 32'h80000000;
    localparam logic [31:0] INNER_LEN_BITS = 32'h00000240;
    localparam logic [31:0] OUTER_LEN_BITS = 32'h000002A0;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
    } t_core_cmd;

    function automatic logic [29:0] pow_ten(input logic [3:0] nd);
        logic [29:0] p;
        case (nd)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- src/hotp_totp_generator.sv -----
// ----------------------------------------------------------------------------
// hotp_totp_generator
// hotp / totp one-time password generator: hmac-sha1 over the moving factor,
// dynamic truncation, reduction modulo ten to the digits
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | i_valid / o_stall  | i_mode, i_key_index, i_key_byte, i_count_value
//  result    | o_valid / i_stall  | o_otp_value
//  config    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  a key write or an ignored mode gives no result
//  hotp: four sha-1 blocks with key-store reads for the key blocks, then
//  truncation and modulo; totp first runs the divider
//  a single sha-1 round unit does all hashing; one request is in work at a time
//  a finished result sits in the output register, so the next request is taken
//  while it waits; reset is synchronous, active low, and leaves the key store
//  undefined until written
// ----------------------------------------------------------------------------
module hotp_totp_generator #(
    parameter int KEY_BYTES = hotp_pkg::KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_key_index,
    input  logic [7:0]  i_key_byte,
    input  logic [63:0] i_count_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [29:0] o_otp_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // key store organized as words of four bytes, first byte in the top lane
    localparam int KW = (KEY_BYTES + 3) / 4;
    localparam int AW = (KW > 1) ? $clog2(KW) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_IN1   = 4'd2;
    localparam logic [3:0] S_IN2   = 4'd3;
    localparam logic [3:0] S_COPY  = 4'd4;
    localparam logic [3:0] S_OUT1  = 4'd5;
    localparam logic [3:0] S_OUT2  = 4'd6;
    localparam logic [3:0] S_TRUNC = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;

    logic [31:0] r_mem [KW];
    logic [31:0] r_kq;

    logic [3:0]   r_state, n_state;
    logic [6:0]   r_key_len;
    logic [3:0]   r_digits;
    logic [15:0]  r_time_step;
    logic [63:0]  r_factor;
    logic [159:0] r_imac;
    logic         r_rd_pend, n_rd_pend;
    logic         r_ovalid;
    logic [29:0]  r_otp;
    logic [30:0]  r_rem;
    logic [59:0]  r_msh;
    logic [4:0]   r_mcnt;

    hotp_pkg::t_core_cmd core_cmd;
    logic [6:0]   round;
    logic [159:0] digest;

    logic        accept, cfg_wr, div_start, div_done, rd_en, load_out;
    logic [63:0] quot;
    logic [6:0]  klen;
    logic [3:0]  nd;
    logic [31:0] key_word, msg_word;
    logic [7:0]  pad;
    logic [159:0] shifted;
    logic [30:0] code;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign load_out = (r_state == S_RES) && (!r_ovalid || !i_stall);

    // register reads
    always_comb begin
        case (paddr[3:2])
            hotp_pkg::REG_KEY_LEN:   prdata = {25'd0, r_key_len};
            hotp_pkg::REG_DIGITS:    prdata = {28'd0, r_digits};
            hotp_pkg::REG_TIME_STEP: prdata = {16'd0, r_time_step};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len   <= 7'd0;
            r_digits    <= 4'd6;
            r_time_step <= 16'd30;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                hotp_pkg::REG_KEY_LEN:   r_key_len   <= pwdata[6:0];
                hotp_pkg::REG_DIGITS:    r_digits    <= pwdata[3:0];
                hotp_pkg::REG_TIME_STEP: r_time_step <= pwdata[15:0];
                default:                 r_key_len   <= r_key_len;
            endcase
        end
    end

    // saturated views of the registers
    assign klen = (r_key_len > 7'(KEY_BYTES)) ? 7'(KEY_BYTES) : r_key_len;
    assign nd   = (r_digits > 4'd9) ? 4'd9 : r_digits;

    // key store: byte-lane write when a key request is accepted, word read
    // registered in the cycle before the round that consumes it; requests are
    // only taken in idle so a write never overlaps a read of the same word
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == hotp_pkg::MODE_KEY
                && {1'b0, i_key_index} < 7'(KEY_BYTES)) begin
            r_mem[AW'(i_key_index[5:2])][8*(3 - int'(i_key_index[1:0])) +: 8] <= i_key_byte;
        end
        if (rd_en) begin
            r_kq <= r_mem[AW'(round[3:0])];
        end
    end

    // key bytes at or past the key length read as zero before padding
    always_comb begin
        pad = (r_state == S_IN1) ? hotp_pkg::IPAD : hotp_pkg::OPAD;
        for (int j = 0; j < 4; j++) begin
            if ({round[3:0], 2'(j)} < klen[5:0] || klen[6]) begin
                key_word[8*(3-j) +: 8] = (32'(round) < 32'(KW)) ? r_kq[8*(3-j) +: 8] : 8'd0;
            end else begin
                key_word[8*(3-j) +: 8] = 8'd0;
            end
            key_word[8*(3-j) +: 8] = key_word[8*(3-j) +: 8] ^ pad;
        end
    end

    // second block of each hash: message tail, padding and bit length
    always_comb begin
        msg_word = '0;
        if (r_state == S_IN2) begin
            case (round[3:0])
                4'd0:    msg_word = r_factor[63:32];
                4'd1:    msg_word = r_factor[31:0];
                4'd2:    msg_word = hotp_pkg::PAD_WORD;
                4'd15:   msg_word = hotp_pkg::INNER_LEN_BITS;
                default: msg_word = '0;
            endcase
        end else begin
            case (round[3:0])
                4'd0:    msg_word = r_imac[159:128];
                4'd1:    msg_word = r_imac[127:96];
                4'd2:    msg_word = r_imac[95:64];
                4'd3:    msg_word = r_imac[63:32];
                4'd4:    msg_word = r_imac[31:0];
                4'd5:    msg_word = hotp_pkg::PAD_WORD;
                4'd15:   msg_word = hotp_pkg::OUTER_LEN_BITS;
                default: msg_word = '0;
            endcase
        end
    end

    // dynamic truncation: low nibble of the last mac byte picks four bytes
    always_comb begin
        shifted = digest << {digest[3:0], 3'b000};
        code    = shifted[158:128];
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_rd_pend     = r_rd_pend;
        core_cmd.op   = hotp_pkg::CORE_NOP;
        core_cmd.word = '0;
        div_start     = 1'b0;
        rd_en         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_mode == hotp_pkg::MODE_HOTP) begin
                    core_cmd.op = hotp_pkg::CORE_INIT;
                    n_rd_pend   = 1'b0;
                    n_state     = S_IN1;
                end else if (accept && i_mode == hotp_pkg::MODE_TOTP) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    core_cmd.op = hotp_pkg::CORE_INIT;
                    n_rd_pend   = 1'b0;
                    n_state     = S_IN1;
                end
            end
            S_IN1, S_OUT1: begin
                if (round == hotp_pkg::ROUNDS) begin
                    core_cmd.op = hotp_pkg::CORE_FOLD;
                    n_state     = (r_state == S_IN1) ? S_IN2 : S_OUT2;
                end else if (round < 7'd16 && !r_rd_pend) begin
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                end else begin
                    core_cmd.op   = hotp_pkg::CORE_STEP;
                    core_cmd.word = key_word;
                    n_rd_pend     = 1'b0;
                end
            end
            S_IN2, S_OUT2: begin
                if (round == hotp_pkg::ROUNDS) begin
                    core_cmd.op = hotp_pkg::CORE_FOLD;
                    n_state     = (r_state == S_IN2) ? S_COPY : S_TRUNC;
                end else begin
                    core_cmd.op   = hotp_pkg::CORE_STEP;
                    core_cmd.word = msg_word;
                end
            end
            S_COPY: begin
                core_cmd.op = hotp_pkg::CORE_INIT;
                n_rd_pend   = 1'b0;
                n_state     = S_OUT1;
            end
            S_TRUNC: n_state = S_MOD;
            S_MOD: begin
                if (r_mcnt == 5'd0) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_ovalid  <= 1'b0;
            r_mcnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_TRUNC) begin
                r_mcnt <= 5'd30;
            end else if (r_state == S_MOD && r_mcnt != 5'd0) begin
                r_mcnt <= r_mcnt - 5'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == hotp_pkg::MODE_HOTP) begin
            r_factor <= i_count_value;
        end else if (r_state == S_DIV && div_done) begin
            r_factor <= quot;
        end
        if (r_state == S_COPY) begin
            r_imac <= digest;
        end
        // restoring reduction: subtract the modulus shifted by 30 down to 0
        if (r_state == S_TRUNC) begin
            r_rem <= code;
            r_msh <= {hotp_pkg::pow_ten(nd), 30'd0};
        end else if (r_state == S_MOD) begin
            if ({29'd0, r_rem} >= r_msh) begin
                r_rem <= 31'({29'd0, r_rem} - r_msh);
            end
            r_msh <= {1'b0, r_msh[59:1]};
        end
        if (load_out) begin
            r_otp <= r_rem[29:0];
        end
    end

    assign o_valid     = r_ovalid;
    assign o_otp_value = r_otp;

    hotp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_count_value),
        .i_divisor  (r_time_step),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    hotp_sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (core_cmd),
        .o_round  (round),
        .o_digest (digest)
    );

    a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD |-> {29'd0, r_rem} < {r_msh, 1'b0})
        else $error("remainder escaped restoring bound");
    a_res_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RES && !i_stall |=> o_valid && r_state == S_IDLE)
        else $error("finished result not delivered");
    a_read_key_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_state == S_IN1 || r_state == S_OUT1) && round < 7'd16)
        else $error("key store read outside key block");

endmodule

// ----- src/hotp_sha1_core.sv -----
// ----------------------------------------------------------------------------
// hotp_sha1_core
// one sha-1 round per step, schedule kept in a sixteen word window
// ----------------------------------------------------------------------------
module hotp_sha1_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hotp_pkg::t_core_cmd   i_cmd,
    output logic [6:0]            o_round,
    output logic [159:0]          o_digest
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [31:0] r_win [16];
    logic [6:0]  r_round;

    logic [31:0] w_cur, w_x, f, k, t;
    logic [31:0] s0, s1, s2, s3, s4;

    always_comb begin
        w_x   = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_cur = (r_round < 7'd16) ? i_cmd.word : {w_x[30:0], w_x[31]};
        if (r_round < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = 32'hCA62C1D6;
        end
        t  = {r_a[26:0], r_a[31:27]} + f + r_e + k + w_cur;
        s0 = r_h0 + r_a;
        s1 = r_h1 + r_b;
        s2 = r_h2 + r_c;
        s3 = r_h3 + r_d;
        s4 = r_h4 + r_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else begin
            case (i_cmd.op)
                hotp_pkg::CORE_INIT: r_round <= '0;
                hotp_pkg::CORE_STEP: r_round <= r_round + 7'd1;
                hotp_pkg::CORE_FOLD: r_round <= '0;
                default:             r_round <= r_round;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            hotp_pkg::CORE_INIT: begin
                r_h0 <= hotp_pkg::IV0; r_a <= hotp_pkg::IV0;
                r_h1 <= hotp_pkg::IV1; r_b <= hotp_pkg::IV1;
                r_h2 <= hotp_pkg::IV2; r_c <= hotp_pkg::IV2;
                r_h3 <= hotp_pkg::IV3; r_d <= hotp_pkg::IV3;
                r_h4 <= hotp_pkg::IV4; r_e <= hotp_pkg::IV4;
            end
            hotp_pkg::CORE_STEP: begin
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= t;
                for (int j = 0; j < 15; j++) begin
                    r_win[j] <= r_win[j+1];
                end
                r_win[15] <= w_cur;
            end
            hotp_pkg::CORE_FOLD: begin
                r_h0 <= s0; r_a <= s0;
                r_h1 <= s1; r_b <= s1;
                r_h2 <= s2; r_c <= s2;
                r_h3 <= s3; r_d <= s3;
                r_h4 <= s4; r_e <= s4;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_round  = r_round;
    assign o_digest = {r_h0, r_h1, r_h2, r_h3, r_h4};

    a_round_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= hotp_pkg::ROUNDS)
        else $error("round counter past last round");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == hotp_pkg::CORE_STEP |-> r_round < hotp_pkg::ROUNDS)
        else $error("step issued after last round");
    a_fold_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == hotp_pkg::CORE_FOLD |=> r_round == 7'd0)
        else $error("fold did not restart block");

endmodule

// ----- src/hotp_div.sv -----
// ----------------------------------------------------------------------------
// hotp_div
// restoring divider, 64-bit time by 16-bit step, one quotient bit a cycle
// ----------------------------------------------------------------------------
module hotp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [15:0] r_r, r_dv;
    logic [16:0] trial;
    logic        fits;

    always_comb begin
        trial = {r_r, r_q[63]};
        fits  = trial >= {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= i_dividend;
            r_r  <= '0;
            // a zero step divides by one
            r_dv <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], fits};
            r_r <= fits ? 16'(trial - {1'b0, r_dv}) : trial[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_r < r_dv)
        else $error("partial remainder not below divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still dividing");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the hotp / totp generator: requests from a queue,
// an hmac-sha1 predictor of its own, apb register phases, random stalls
// ----------------------------------------------------------------------------
module testbench;

    localparam int  KEY_BYTES = 64;
    localparam int  DRAIN     = 500;        // extra wait once every password has come, with margin
    localparam longint LIMIT  = 3000000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  key_index;
        logic [7:0]  key_byte;
        logic [63:0] count_value;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [5:0]  i_key_index;
    logic [7:0]  i_key_byte;
    logic [63:0] i_count_value;
    logic        o_valid;
    logic        i_stall;
    logic [29:0] o_otp_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hotp_totp_generator DUT (.*);

    // ------------------------------------------------------------------
    // clock, cycle counter and timeout
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    longint cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor state: own copy of the registers and the key store
    // ------------------------------------------------------------------
    logic [7:0]  key_mem [0:KEY_BYTES-1];
    logic [63:0] key_written;               // one bit per key byte ever written
    logic [6:0]  cfg_key_len;
    logic [3:0]  cfg_digits;
    logic [15:0] cfg_time_step;
    logic [7:0]  hash_buf [0:127];          // scratch message for the hash

    t_request    pending_reqs[$];
    logic [29:0] expected_otps[$];
    int          errors = 0;
    bit          quiet = 0;                 // no idling on either side

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one sha-1 compression of the 64 bytes at hash_buf[base]
    function automatic logic [159:0] sha1_compress(input logic [159:0] hin, input int base);
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        a = hin[159:128]; b = hin[127:96]; c = hin[95:64]; d = hin[63:32]; e = hin[31:0];
        for (int i = 0; i < 16; i++)
            w[i] = {hash_buf[base+4*i], hash_buf[base+4*i+1],
                    hash_buf[base+4*i+2], hash_buf[base+4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
                hin[63:32] + d, hin[31:0] + e};
    endfunction

    // sha-1 of the first len bytes of hash_buf, len below 120
    function automatic logic [159:0] sha1_of_buf(input int len);
        logic [159:0] h;
        logic [63:0]  bits;
        int           blocks;
        h = {hotp_pkg::IV0, hotp_pkg::IV1, hotp_pkg::IV2, hotp_pkg::IV3, hotp_pkg::IV4};
        bits = 64'(len) * 64'd8;
        blocks = (len + 9 + 63) / 64;
        for (int i = len; i < 128; i++) hash_buf[i] = 8'h00;
        hash_buf[len] = 8'h80;
        for (int i = 0; i < 8; i++) hash_buf[blocks*64-1-i] = bits[8*i +: 8];
        for (int i = 0; i < blocks; i++) h = sha1_compress(h, 64 * i);
        return h;
    endfunction

    // hmac-sha1 of the moving factor, dynamic truncation, reduction by digits
    function automatic logic [29:0] otp_for_factor(input logic [63:0] factor);
        logic [159:0] mac;
        logic [7:0]   kb [0:63];
        logic [7:0]   mb [0:19];
        logic [31:0]  code;
        logic [31:0]  modulus;
        int           klen, nd, off;
        klen = (int'(cfg_key_len) > KEY_BYTES) ? KEY_BYTES : int'(cfg_key_len);
        nd = (int'(cfg_digits) > 9) ? 9 : int'(cfg_digits);
        for (int i = 0; i < 64; i++) kb[i] = (i < klen) ? key_mem[i] : 8'h00;
        // inner hash over key ^ ipad then the factor, most significant byte first
        for (int i = 0; i < 64; i++) hash_buf[i] = kb[i] ^ hotp_pkg::IPAD;
        for (int i = 0; i < 8; i++) hash_buf[64+i] = factor[8*(7-i) +: 8];
        mac = sha1_of_buf(72);
        // outer hash over key ^ opad then the inner digest
        for (int i = 0; i < 64; i++) hash_buf[i] = kb[i] ^ hotp_pkg::OPAD;
        for (int i = 0; i < 20; i++) hash_buf[64+i] = mac[159-8*i -: 8];
        mac = sha1_of_buf(84);
        for (int i = 0; i < 20; i++) mb[i] = mac[159-8*i -: 8];
        off = int'(mb[19] & 8'h0F);
        code = {mb[off] & 8'h7F, mb[off+1], mb[off+2], mb[off+3]};
        modulus = 32'd1;
        for (int i = 0; i < nd; i++) modulus = modulus * 32'd10;
        return 30'(code % modulus);
    endfunction

    // ------------------------------------------------------------------
    // driver: request channel, inputs change on the falling edge
    // ------------------------------------------------------------------
    bit req_taken = 0;
    int req_wait  = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            req_taken = 0;
            if (req_wait > 0) begin
                i_valid <= 1'b0;
                req_wait = req_wait - 1;
            end else if (pending_reqs.size() > 0) begin
                t_request r;
                r = pending_reqs.pop_front();
                i_mode        <= r.mode;
                i_key_index   <= r.key_index;
                i_key_byte    <= r.key_byte;
                i_count_value <= r.count_value;
                i_valid       <= 1'b1;
                req_wait = quiet ? 0 : $urandom_range(0, 13);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // accepted request: update the key store or queue the expected password
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            req_taken = 1;
            case (i_mode)
                hotp_pkg::MODE_KEY: begin
                    key_mem[i_key_index] = i_key_byte;
                    key_written[i_key_index] = 1'b1;
                end
                hotp_pkg::MODE_HOTP: expected_otps.push_back(otp_for_factor(i_count_value));
                hotp_pkg::MODE_TOTP: expected_otps.push_back(otp_for_factor(
                    i_count_value / ((cfg_time_step == 0) ? 64'd1 : 64'(cfg_time_step))));
                default: ;  // mode three is ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: result channel with random stall
    // ------------------------------------------------------------------
    int rsp_wait = 0;

    always @(negedge i_clk) begin
        if (rsp_wait > 0) begin
            i_stall <= 1'b1;
            rsp_wait = rsp_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_otps.size() == 0) begin
                $error("otp_value: unexpected result %0d", o_otp_value);
                errors++;
            end else begin
                logic [29:0] want;
                want = expected_otps.pop_front();
                if (o_otp_value !== want) begin
                    $error("otp_value: expected %0d, actual %0d", want, o_otp_value);
                    errors++;
                end
            end
            rsp_wait = quiet ? 0 : $urandom_range(0, 13);
        end
    end

    // ------------------------------------------------------------------
    // apb register write: setup cycle then access cycle
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            hotp_pkg::REG_KEY_LEN:   cfg_key_len   = value[6:0];
            hotp_pkg::REG_DIGITS:    cfg_digits    = value[3:0];
            hotp_pkg::REG_TIME_STEP: cfg_time_step = value[15:0];
            default: ;
        endcase
    endtask

    // wait until every queued request is sent and every password has come
    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_otps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic int written_prefix();
        int p;
        p = 0;
        while (p < KEY_BYTES && key_written[p]) p++;
        return p;
    endfunction

    function automatic t_request mk(input logic [1:0] m, input logic [5:0] ix,
                                    input logic [7:0] kb, input logic [63:0] cv);
        t_request r;
        r.mode = m; r.key_index = ix; r.key_byte = kb; r.count_value = cv;
        return r;
    endfunction

    // random request, mostly password generation with random factor
    function automatic t_request rand_req();
        int          pick;
        logic [63:0] cv;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       cv = {$urandom, $urandom};
            1:       cv = 64'($urandom);
            2:       cv = {32'h0, $urandom} | ({$urandom, $urandom} & 64'hFFFF_FFFF_0000_0000);
            default: cv = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
        endcase
        if (pick < 30)
            return mk(hotp_pkg::MODE_KEY, 6'($urandom_range(0, 63)), 8'($urandom), cv);
        else if (pick < 62)
            return mk(hotp_pkg::MODE_HOTP, 6'($urandom), 8'($urandom), cv);
        else if (pick < 94)
            return mk(hotp_pkg::MODE_TOTP, 6'($urandom), 8'($urandom), cv);
        else
            return mk(2'd3, 6'($urandom), 8'($urandom), cv);
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int p;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_mode = '0; i_key_index = '0; i_key_byte = '0; i_count_value = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        key_written = '0;
        cfg_key_len = 7'd0; cfg_digits = 4'd6; cfg_time_step = 16'd30;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty key at reset values, then a 20 byte ascii key
        quiet = 1;
        pending_reqs.push_back(mk(hotp_pkg::MODE_HOTP, 6'd0, 8'd0, 64'd0));
        pending_reqs.push_back(mk(hotp_pkg::MODE_TOTP, 6'd0, 8'd0, 64'd59));
        for (int i = 0; i < 20; i++)
            pending_reqs.push_back(mk(hotp_pkg::MODE_KEY, 6'(i),
                                      8'h30 + 8'((i + 1) % 10), 64'd0));
        drain();
        reg_write(hotp_pkg::REG_KEY_LEN, 32'd20);
        reg_write(hotp_pkg::REG_DIGITS, 32'd9);
        reg_write(hotp_pkg::REG_TIME_STEP, 32'd0);    // step zero acts as one
        pending_reqs.push_back(mk(hotp_pkg::MODE_HOTP, 6'd0, 8'd0, 64'd0));
        pending_reqs.push_back(mk(hotp_pkg::MODE_HOTP, 6'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(mk(hotp_pkg::MODE_TOTP, 6'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(mk(2'd3, 6'h3F, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(mk(hotp_pkg::MODE_KEY, 6'd63, 8'hFF, 64'd0));
        pending_reqs.push_back(mk(hotp_pkg::MODE_KEY, 6'd21, 8'h00, 64'd0));
        drain();
        reg_write(hotp_pkg::REG_DIGITS, 32'd0);       // modulus one
        reg_write(hotp_pkg::REG_TIME_STEP, 32'd65535);
        pending_reqs.push_back(mk(hotp_pkg::MODE_HOTP, 6'd0, 8'd0, 64'd1));
        pending_reqs.push_back(mk(hotp_pkg::MODE_TOTP, 6'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        drain();

        // random phases, each behind a fresh register setting
        for (int ph = 0; ph < 10; ph++) begin
            p = written_prefix();
            case (ph % 4)
                0: reg_write(hotp_pkg::REG_KEY_LEN, 32'(p));
                1: reg_write(hotp_pkg::REG_KEY_LEN, 32'($urandom_range(0, p)));
                2: reg_write(hotp_pkg::REG_KEY_LEN,
                             (p == KEY_BYTES) ? 32'($urandom_range(64, 127)) : 32'd0);
                default: reg_write(hotp_pkg::REG_KEY_LEN, 32'(p));
            endcase
            reg_write(hotp_pkg::REG_DIGITS,
                      (ph % 3 == 0) ? 32'd15 : 32'($urandom_range(0, 15)));
            reg_write(hotp_pkg::REG_TIME_STEP, (ph == 4) ? 32'd1 :
                      (ph == 7) ? 32'd65535 : 32'($urandom_range(0, 65535)));
            quiet = (ph % 5 == 2);
            for (int n = 0; n < 100; n++) pending_reqs.push_back(rand_req());
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
